### rtl/perspective_viewport_projection_top_assert.svh
// Assertion macros for the perspective viewport projection block.
// Included by the top level; no other dependencies.
`ifndef PERSPECTIVE_VIEWPORT_PROJECTION_TOP_ASSERT_SVH
`define PERSPECTIVE_VIEWPORT_PROJECTION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PVP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pvp assertion failed");
`define PVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pvp assertion failed");
`else
`define PVP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PVP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/pvp_pkg.sv
// Shared types and constants of the perspective viewport projection block.
// No dependencies.
package pvp_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
	localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
	localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
	localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
	localparam logic [2:0] REG_ROW3_COLS01 = 3'd4;
	localparam logic [2:0] REG_ROW3_COLS23 = 3'd5;
	localparam logic [2:0] REG_SCREEN_SIZE = 3'd6;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} pvp_point_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] clip_w;
		logic               w_zero;
	} pvp_result_t;

	// Clip-space values handed from the front to the back.
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] w;
	} pvp_clip_t;

	// Matrix rows 0, 1 and 3 plus the screen size.
	typedef struct packed {
		logic [63:0] row0_cols01;
		logic [63:0] row0_cols23;
		logic [63:0] row1_cols01;
		logic [63:0] row1_cols23;
		logic [63:0] row3_cols01;
		logic [63:0] row3_cols23;
		logic [31:0] screen_size;
	} pvp_cfg_t;

	// Queue-style handshake between a producer and a queue.
	typedef struct packed {
		logic push;
		logic full;
	} pvp_qlink_t;

endpackage

### rtl/pvp_fifo.sv
// Small first-in first-out queue with a fall-through read port.
// Generic over the item type; no package dependencies.
module pvp_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end
endmodule

### rtl/pvp_front.sv
// Front end: accepts points and forms the clip-space dot products of rows 0, 1 and 3.
// Depends on pvp_pkg.
module pvp_front import pvp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pvp_cfg_t   cfg,
	input  logic       in_valid,
	input  pvp_point_t point,
	output logic       in_ready,
	output pvp_qlink_t mid,
	input  logic       mid_full,
	output pvp_clip_t  clip
);
	logic signed [31:0] coef [3][4];
	logic [63:0]        row_lo [3];
	logic [63:0]        row_hi [3];

	logic               v_s1, v_s2, v_s3;
	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] m3_s1 [3];
	logic signed [65:0] sum_s2 [3];
	logic signed [31:0] m3_s2 [3];
	pvp_clip_t          clip_s3;
	logic signed [31:0] sat_val [3];
	logic               en;

	// The whole front advances unless its last stage is blocked by the queue.
	assign en       = !(v_s3 && mid_full);
	assign in_ready = en;
	assign mid.push = v_s3 && en;
	assign mid.full = mid_full;
	assign clip     = clip_s3;

	// Unpack the coefficient words of each row.
	always_comb begin
		row_lo[0] = cfg.row0_cols01;
		row_hi[0] = cfg.row0_cols23;
		row_lo[1] = cfg.row1_cols01;
		row_hi[1] = cfg.row1_cols23;
		row_lo[2] = cfg.row3_cols01;
		row_hi[2] = cfg.row3_cols23;
		for (int r = 0; r < 3; r++) begin
			coef[r][0] = row_lo[r][63:32];
			coef[r][1] = row_lo[r][31:0];
			coef[r][2] = row_hi[r][63:32];
			coef[r][3] = row_hi[r][31:0];
		end
	end

	// Round the Q32.32 sum down to Q16.16, add the translation and saturate.
	always_comb begin
		logic signed [65:0] v;
		for (int r = 0; r < 3; r++) begin
			v = (sum_s2[r] >>> 16) + 66'(m3_s2[r]);
			if (v > 66'sd2147483647) begin
				sat_val[r] = 32'sh7fff_ffff;
			end else if (v < -66'sd2147483648) begin
				sat_val[r] = 32'sh8000_0000;
			end else begin
				sat_val[r] = v[31:0];
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Products, sums and the saturated results.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= coef[r][0] * point.point_x;
				prod_s1[r][1] <= coef[r][1] * point.point_y;
				prod_s1[r][2] <= coef[r][2] * point.point_z;
				m3_s1[r]      <= coef[r][3];
				sum_s2[r]     <= 66'(prod_s1[r][0]) + 66'(prod_s1[r][1])
					+ 66'(prod_s1[r][2]);
				m3_s2[r]      <= m3_s1[r];
			end
			clip_s3.cx <= sat_val[0];
			clip_s3.cy <= sat_val[1];
			clip_s3.w  <= sat_val[2];
		end
	end
endmodule

### rtl/pvp_back.sv
// Back end: viewport mapping and pipelined division by w, one quotient bit per stage.
// Depends on pvp_pkg.
module pvp_back import pvp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pvp_cfg_t    cfg,
	input  logic        mid_empty,
	input  pvp_clip_t   clip,
	output logic        mid_pop,
	output pvp_qlink_t  out,
	input  logic        out_full,
	output pvp_result_t result
);
	localparam int QW = 32;

	typedef struct packed {
		logic [63:0]        rem_x;
		logic [63:0]        rem_y;
		logic [QW-1:0]      q_x;
		logic [QW-1:0]      q_y;
		logic [31:0]        dmag;
		logic               neg_x;
		logic               neg_y;
		logic               ovf_x;
		logic               ovf_y;
		logic               wz;
		logic signed [31:0] w;
	} pvp_div_t;

	logic               en;
	logic               v_s1, v_s2, v_s3;
	logic signed [32:0] num_x_s1, num_y_s1;
	logic signed [31:0] w_s1, w_s2;
	logic               wz_s1, wz_s2;
	logic signed [49:0] prod_x_s2, prod_y_s2;
	logic [QW:0]        div_v;
	pvp_div_t           div_s [QW+1];
	logic               v_fin;
	pvp_result_t        fin_q;
	logic [15:0]        wd;
	logic [15:0]        ht;
	logic [49:0]        mag_x, mag_y;
	logic [31:0]        dmag;
	pvp_div_t           div_init;

	assign wd      = cfg.screen_size[31:16];
	assign ht      = cfg.screen_size[15:0];
	assign en      = !(v_fin && out_full);
	assign mid_pop = en && !mid_empty;
	assign out.push = v_fin && en;
	assign out.full = out_full;
	assign result  = fin_q;
	assign div_v[0] = v_s3;

	// Magnitudes, signs and the early overflow test that open the division.
	always_comb begin
		mag_x = prod_x_s2[49] ? 50'(-prod_x_s2) : 50'(prod_x_s2);
		mag_y = prod_y_s2[49] ? 50'(-prod_y_s2) : 50'(prod_y_s2);
		dmag  = w_s2[31] ? 32'(-w_s2) : 32'(w_s2);
		div_init.rem_x = 64'(mag_x) << 15;
		div_init.rem_y = 64'(mag_y) << 15;
		div_init.q_x   = '0;
		div_init.q_y   = '0;
		div_init.dmag  = dmag;
		div_init.neg_x = prod_x_s2[49] ^ w_s2[31];
		div_init.neg_y = prod_y_s2[49] ^ w_s2[31];
		div_init.ovf_x = (64'(mag_x) << 15) >= {dmag, 32'b0};
		div_init.ovf_y = (64'(mag_y) << 15) >= {dmag, 32'b0};
		div_init.wz    = wz_s2;
		div_init.w     = w_s2;
	end

	// Numerators, scaling by screen size, and division setup.
	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s1  <= 33'(clip.w) + 33'(clip.cx);
			num_y_s1  <= 33'(clip.w) - 33'(clip.cy);
			w_s1      <= clip.w;
			wz_s1     <= (clip.w == '0);
			prod_x_s2 <= num_x_s1 * $signed({1'b0, wd});
			prod_y_s2 <= num_y_s1 * $signed({1'b0, ht});
			w_s2      <= w_s1;
			wz_s2     <= wz_s1;
			div_s[0]  <= div_init;
		end
	end

	// Restoring division stages, most significant quotient bit first.
	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int BIT = QW - 1 - k;
		logic [63:0] sub;
		pvp_div_t    nxt;

		assign sub = 64'(div_s[k].dmag) << BIT;

		always_comb begin
			nxt = div_s[k];
			if (div_s[k].rem_x >= sub) begin
				nxt.rem_x    = div_s[k].rem_x - sub;
				nxt.q_x[BIT] = 1'b1;
			end
			if (div_s[k].rem_y >= sub) begin
				nxt.rem_y    = div_s[k].rem_y - sub;
				nxt.q_y[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[k+1] <= 1'b0;
			end else if (en) begin
				div_v[k+1] <= div_v[k];
			end
		end
	end

	// Signed saturation of a quotient magnitude.
	function automatic logic [31:0] sat_quot(input logic [QW-1:0] q, input logic neg,
		input logic ovf);
		if (neg) begin
			sat_quot = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
		end else begin
			sat_quot = (ovf || q[QW-1]) ? 32'h7fff_ffff : q;
		end
	endfunction

	// Valid bits of the opening stages and the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_fin <= 1'b0;
		end else if (en) begin
			v_s1  <= mid_pop;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_fin <= div_v[QW];
		end
	end

	// Result stage; a zero w forces zero coordinates.
	always_ff @(posedge clk) begin
		if (en) begin
			if (div_s[QW].wz) begin
				fin_q.screen_x <= '0;
				fin_q.screen_y <= '0;
				fin_q.clip_w   <= '0;
				fin_q.w_zero   <= 1'b1;
			end else begin
				fin_q.screen_x <= sat_quot(div_s[QW].q_x, div_s[QW].neg_x, div_s[QW].ovf_x);
				fin_q.screen_y <= sat_quot(div_s[QW].q_y, div_s[QW].neg_y, div_s[QW].ovf_y);
				fin_q.clip_w   <= div_s[QW].w;
				fin_q.w_zero   <= 1'b0;
			end
		end
	end
endmodule

### rtl/perspective_viewport_projection_top.sv
// Perspective projection and viewport mapping: one 3-D point in, one screen
// position out every cycle while downstream keeps popping. The block takes a new
// point in every clock cycle while downstream keeps popping; a point spends 3 front
// stages in the dot-product multipliers, passes the middle queue, then 36 back
// stages (numerator, scaling, setup, 32 one-bit division stages shared by both
// coordinates, result). Matrix rows and screen size are written through the
// configuration channel, which is always ready; write it only while the block is
// empty. A write to register index 7 is ignored.
// Depends on pvp_pkg, pvp_fifo, pvp_front, pvp_back and the assertion header.
`include "perspective_viewport_projection_top_assert.svh"
module perspective_viewport_projection_top import pvp_pkg::*; #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pvp_point_t             point,
	output logic                   full,
	input  logic                   pop,
	output pvp_result_t            result,
	output logic                   empty,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);
	pvp_cfg_t    cfg_q;
	logic        in_ready;
	pvp_qlink_t  mid_link;
	logic        mid_full;
	logic        mid_empty;
	logic        mid_pop;
	pvp_clip_t   front_clip;
	pvp_clip_t   mid_clip;
	pvp_qlink_t  out_link;
	logic        out_full;
	pvp_result_t back_result;

	assign cfg_ready = 1'b1;
	assign full      = !in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW0_COLS01: cfg_q.row0_cols01 <= cfg_data;
				REG_ROW0_COLS23: cfg_q.row0_cols23 <= cfg_data;
				REG_ROW1_COLS01: cfg_q.row1_cols01 <= cfg_data;
				REG_ROW1_COLS23: cfg_q.row1_cols23 <= cfg_data;
				REG_ROW3_COLS01: cfg_q.row3_cols01 <= cfg_data;
				REG_ROW3_COLS23: cfg_q.row3_cols23 <= cfg_data;
				REG_SCREEN_SIZE: cfg_q.screen_size <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Front end: dot products.
	pvp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (push),
		.point    (point),
		.in_ready (in_ready),
		.mid      (mid_link),
		.mid_full (mid_full),
		.clip     (front_clip)
	);

	// Queue between front and back.
	pvp_fifo #(.T(pvp_clip_t), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_link.push),
		.din    (front_clip),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_clip),
		.empty  (mid_empty)
	);

	// Back end: viewport mapping and division.
	pvp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.clip      (mid_clip),
		.mid_pop   (mid_pop),
		.out       (out_link),
		.out_full  (out_full),
		.result    (back_result)
	);

	// Result queue.
	pvp_fifo #(.T(pvp_result_t), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_link.push),
		.din    (back_result),
		.full   (out_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

	// A zero w always comes with zero coordinates, and a nonzero w is reported as such.
	`PVP_ASSERT_IMPLY(a_wzero_clears, clk, arst_n, !empty && result.w_zero, result.screen_x == 0 && result.screen_y == 0 && result.clip_w == 0)
	`PVP_ASSERT_IMPLY(a_w_nonzero, clk, arst_n, !empty && !result.w_zero, result.clip_w != 0)
	// The back end never pushes into a full result queue.
	`PVP_ASSERT_IMPLY(a_out_no_overflow, clk, arst_n, out_link.push, !out_full)
	// A stalled input side means the middle queue was full.
	`PVP_ASSERT_IMPLY(a_full_cause, clk, arst_n, full, mid_full)
endmodule

### sim/testbench.sv
// Self-checking testbench for the perspective viewport projection block.
// Depends on pvp_pkg and perspective_viewport_projection_top; it predicts every result itself.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pvp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASES = 9;
	localparam int POINTS_PER_PHASE = 180;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
	localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN32 = 32'h8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	pvp_point_t point = '0;
	logic full;
	logic pop = 1'b0;
	pvp_result_t result;
	logic empty;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the matrix rows and screen size.
	logic [63:0] matrix_regs [6];
	logic [31:0] screen_reg;

	pvp_point_t points_to_send [$];
	pvp_result_t expected_results [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	perspective_viewport_projection_top dut (.*);

	always #2 clk = ~clk;

	function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
		if (v > $signed(96'sh7FFF_FFFF)) return MAX32;
		if (v < -$signed(96'sh8000_0000)) return MIN32;
		return v[31:0];
	endfunction

	// Dot product of one matrix row with (x, y, z, 1), floored to Q16.16 and saturated.
	function automatic logic signed [31:0] row_dot(input int r, input pvp_point_t p);
		logic signed [95:0] m0, m1, m2, m3, px, py, pz, acc;
		m0 = $signed(matrix_regs[r][63:32]);
		m1 = $signed(matrix_regs[r][31:0]);
		m2 = $signed(matrix_regs[r+1][63:32]);
		m3 = $signed(matrix_regs[r+1][31:0]);
		px = p.point_x;
		py = p.point_y;
		pz = p.point_z;
		acc = m0 * px + m1 * py + m2 * pz + (m3 <<< 16);
		return sat32(acc >>> 16);
	endfunction

	// Viewport mapping: trunc(size * num * 2^15 / w), saturated.
	function automatic logic signed [31:0] to_pixels(input logic signed [95:0] num,
			input logic [15:0] size, input logic signed [31:0] w);
		logic signed [95:0] size_wide, w_wide, prod;
		size_wide = 96'(size);
		w_wide = w;
		prod = num * size_wide * 96'sd32768;
		return sat32(prod / w_wide);
	endfunction

	function automatic pvp_result_t project_point(input pvp_point_t p);
		pvp_result_t res;
		logic signed [31:0] cx, cy, w;
		logic signed [95:0] w_wide;
		cx = row_dot(0, p);
		cy = row_dot(2, p);
		w = row_dot(4, p);
		res = '0;
		if (w == 0) begin
			res.w_zero = 1'b1;
			return res;
		end
		w_wide = w;
		res.screen_x = to_pixels(w_wide + cx, screen_reg[31:16], w);
		res.screen_y = to_pixels(w_wide - cy, screen_reg[15:0], w);
		res.clip_w = w;
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
		error_count++;
	endtask

	// Driver: one transaction per accepted point, prediction made on acceptance.
	always @(posedge clk) begin
		if (push && full) begin
			// Hold the current point until it is taken.
		end else begin
			if (push) begin
				expected_results.push_back(project_point(point));
				void'(points_to_send.pop_front());
			end
			if (points_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				push <= 1'b1;
				point <= points_to_send[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: compare each popped result with the oldest expectation.
	always @(posedge clk) begin
		if (pop && !empty) begin
			if (expected_results.size() == 0) begin
				$display("unexpected result at %0t", $time);
				error_count++;
			end else begin
				if (result.screen_x !== expected_results[0].screen_x)
					report_mismatch("screen_x", result.screen_x, expected_results[0].screen_x);
				if (result.screen_y !== expected_results[0].screen_y)
					report_mismatch("screen_y", result.screen_y, expected_results[0].screen_y);
				if (result.clip_w !== expected_results[0].clip_w)
					report_mismatch("clip_w", result.clip_w, expected_results[0].clip_w);
				if (result.w_zero !== expected_results[0].w_zero)
					report_mismatch("w_zero", result.w_zero, expected_results[0].w_zero);
				void'(expected_results.pop_front());
			end
		end
		pop <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: ends the run when no transaction happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SCREEN_SIZE)
			screen_reg = data[31:0];
		else if (idx < REG_SCREEN_SIZE)
			matrix_regs[idx] = data;
	endtask

	task automatic wait_drained();
		while (points_to_send.size() > 0 || expected_results.size() > 0 || push)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [31:0] random_word();
		logic [31:0] pick [5];
		pick = '{32'h0, MAX32, MIN32, ONE, NEG_ONE};
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(32'h000A_0000) - 32'h0005_0000;
			2: return pick[$urandom_range(4)];
			default: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
		endcase
	endfunction

	// Matrix styles: plain perspective (w = z), moderate, raw bits, extremes.
	task automatic load_matrix(input int style, input logic [31:0] screen);
		logic [31:0] m [12];
		for (int i = 0; i < 12; i++) begin
			case (style)
				0: m[i] = (i == 0 || i == 5 || i == 10) ? ONE : 32'h0;
				1: m[i] = $urandom_range(32'h0004_0000) - 32'h0002_0000;
				2: m[i] = $urandom();
				default: m[i] = $urandom_range(1) ? MAX32 : MIN32;
			endcase
		end
		for (int r = 0; r < 6; r++)
			write_reg(r[CFG_INDEX_W-1:0], {m[2*r], m[2*r+1]});
		write_reg(REG_SCREEN_SIZE, {32'h0, screen});
	endtask

	task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		points_to_send.push_back(pvp_point_t'{x, y, z});
	endtask

	initial begin
		int style;
		logic [31:0] screen;
		for (int r = 0; r < 6; r++) matrix_regs[r] = '0;
		screen_reg = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed points under a plain perspective matrix on a 1920x1080 screen.
		load_matrix(0, {16'd1920, 16'd1080});
		write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		add_point(32'h0, 32'h0, 32'h0);
		add_point(ONE, ONE, 32'h0);
		add_point(ONE, ONE, ONE);
		add_point(NEG_ONE, ONE, NEG_ONE);
		add_point(MAX32, MAX32, MAX32);
		add_point(MIN32, MIN32, MIN32);
		add_point(MAX32, MIN32, ONE);
		add_point(MIN32, MAX32, NEG_ONE);
		add_point(ONE, NEG_ONE, 32'h1);
		add_point(MAX32, MAX32, 32'h1);
		add_point(MIN32, MIN32, 32'hFFFF_FFFF);
		add_point(32'h0008_0000, 32'hFFF8_0000, 32'h0002_0000);
		add_point(32'h0, 32'h0, MAX32);
		add_point(32'h0, 32'h0, MIN32);
		add_point(32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_8000);
		wait_drained();

		// Random phases, each with its own idling mode and matrix setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 82; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 82; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			style = (ph + 1) % 4;
			screen = $urandom();
			if (style == 3) screen = 32'hFFFF_FFFF;
			if (ph == 4) screen = 32'h0;
			load_matrix(style, screen);
			for (int i = 0; i < POINTS_PER_PHASE; i++)
				add_point(random_word(), random_word(), random_word());
			wait_drained();
		end

		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
